// ===== rtl/bbvg_pkg.sv =====
// Package for the bubble basis value and gradient block: fixed-point types,
// shape class codes, stage payload structs and the shared arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbvg_pkg;

  localparam int FRAC_BITS = 16;

  // Working value: signed fixed point with FRAC_BITS fraction bits.
  typedef logic signed [31:0] val_t;
  typedef logic signed [17:0] coord_t;
  typedef logic signed [23:0] res_t;
  typedef logic [2:0]         cls_t;

  localparam cls_t CLS_LINE  = 3'd0;
  localparam cls_t CLS_TRI   = 3'd1;
  localparam cls_t CLS_TET   = 3'd2;
  localparam cls_t CLS_QUAD  = 3'd3;
  localparam cls_t CLS_HEX   = 3'd4;
  localparam cls_t CLS_WEDGE = 3'd5;
  localparam cls_t CLS_PYR   = 3'd6;

  localparam val_t       ONE     = 32'sd1 <<< FRAC_BITS;
  localparam logic [63:0] HALF64 = 64'd1 << (FRAC_BITS - 1);
  localparam val_t       OUT_MAX = 32'sd8388607;
  localparam val_t       OUT_MIN = -32'sd8388608;
  localparam int         PYR_NUM = 3125;

  typedef struct packed {
    cls_t cls;
    val_t x, y, z;
    val_t xx, yy, zz, xy;
    val_t l0t, l0q, s;
    val_t n2x, n2y, n2z, p2z;
  } a_t;

  typedef struct packed {
    cls_t cls;
    val_t x, y, z, xy;
    val_t n2x, n2y, n2z;
    val_t mx, my, mz;
    val_t l0tx, l0ty, xyz;
    val_t l0q, l0qx, l0qy;
    val_t zs2, zn2x, ax, ay, asum;
  } b_t;

  typedef struct packed {
    cls_t       cls;
    val_t [3:0] opa;
    val_t [3:0] opb;
    logic [3:0] en;
  } c_t;

  typedef struct packed {
    cls_t       cls;
    val_t [3:0] r;
  } d_t;

  typedef struct packed {
    res_t v, gx, gy, gz;
  } out_t;

  function automatic val_t sext_in(input coord_t c);
    return {{14{c[17]}}, c};
  endfunction

  // Product of two working values, rounded half away from zero.
  function automatic val_t mul_fx(input val_t a, input val_t b);
    logic signed [63:0] p;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] q;
    p = 64'(a) * 64'(b);
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + HALF64) >> FRAC_BITS;
    q = p[63] ? -r : r;
    return q[31:0];
  endfunction

  // Times 3125, then divide by 256 rounding half away from zero.
  function automatic val_t pyr_scale(input val_t a);
    logic signed [47:0] t;
    logic [47:0] m;
    logic [47:0] r;
    logic [47:0] q;
    t = 48'(a) * 48'(PYR_NUM);
    m = t[47] ? 48'(-t) : 48'(t);
    r = (m + 48'd128) >> 8;
    q = t[47] ? -r : r;
    return q[31:0];
  endfunction

  function automatic res_t sat_out(input val_t v);
    res_t r;
    if (v > OUT_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < OUT_MIN) begin
      r = -24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bubble_basis_value_gradient.sv =====
// Bubble shape function value and gradient, top level: shape class register,
// the five-stage datapath (bbvg_front, bbvg_mid, bbvg_back). Uses bbvg_pkg.
//
// Usage:
//   - Write the shape class (0 line .. 6 pyramid) on the cfg channel while
//     the block is idle; cfg_ready is always high. Reset sets class line.
//   - Each item on the input channel carries coord_x/y/z, signed Q1.16.
//     Each item gives one result on the output channel: bubble_value and
//     grad_x/y/z, signed Q7.16, saturated. Unused gradient parts are zero.
//   - Each accepted item passes through stages A..E in order, and out_valid
//     rises once it is in the stage E output register; stages A..D each add
//     one product level. One item per cycle is sustained while out_ready is high.
//   - Every stage carries its own valid bit and loads whenever it is empty
//     or the stage after it moves, so bubbles collapse when the receiver
//     stalls; in_ready drops only once all five stages hold items.
//   - Synchronous reset empties the pipeline and restores the class.
`timescale 1ns / 1ps
`default_nettype none

module bubble_basis_value_gradient (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  shape_class,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [17:0] coord_x,
  input  wire logic signed [17:0] coord_y,
  input  wire logic signed [17:0] coord_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [23:0] bubble_value,
  output logic signed [23:0] grad_x,
  output logic signed [23:0] grad_y,
  output logic signed [23:0] grad_z
);

  bbvg_pkg::cls_t cls;
  logic           fb_valid, fb_ready;
  logic           mb_valid, mb_ready;
  bbvg_pkg::b_t   fb_data;
  bbvg_pkg::c_t   mb_data;
  bbvg_pkg::out_t res;
  logic [2:0]     inflight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls <= bbvg_pkg::CLS_LINE;
    end else if (cfg_valid && cfg_ready) begin
      cls <= shape_class;
    end
  end

  bbvg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cls       (cls),
    .x         (bbvg_pkg::sext_in(coord_x)),
    .y         (bbvg_pkg::sext_in(coord_y)),
    .z         (bbvg_pkg::sext_in(coord_z)),
    .out_valid (fb_valid),
    .out_ready (fb_ready),
    .out_data  (fb_data)
  );

  bbvg_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fb_valid),
    .in_ready  (fb_ready),
    .in_data   (fb_data),
    .out_valid (mb_valid),
    .out_ready (mb_ready),
    .out_data  (mb_data)
  );

  bbvg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mb_valid),
    .in_ready  (mb_ready),
    .in_data   (mb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign bubble_value = res.v;
  assign grad_x       = res.gx;
  assign grad_y       = res.gy;
  assign grad_z       = res.gz;

  // Track items between acceptance and delivery.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight + 3'((in_valid && in_ready) ? 1 : 0)
                           - 3'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (rst) inflight <= 3'd5)
    else $error("more items in flight than pipeline stages");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 3'd0)
    else $error("result shown with no item in flight");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && inflight == 3'd5)
    else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire

// ===== rtl/bbvg_front.sv =====
// Front stages: squares, cross products and barycentric terms of the
// coordinates (stage A), then the second product level (stage B). Uses bbvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbvg_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bbvg_pkg::cls_t cls,
  input  wire bbvg_pkg::val_t x,
  input  wire bbvg_pkg::val_t y,
  input  wire bbvg_pkg::val_t z,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bbvg_pkg::b_t       out_data
);

  logic va, vb;
  logic en_a, en_b;
  bbvg_pkg::a_t ra, a_next;
  bbvg_pkg::b_t rb, b_next;

  assign en_b     = !vb || out_ready;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_comb begin
    a_next.cls = cls;
    a_next.x   = x;
    a_next.y   = y;
    a_next.z   = z;
    a_next.xx  = bbvg_pkg::mul_fx(x, x);
    a_next.yy  = bbvg_pkg::mul_fx(y, y);
    a_next.zz  = bbvg_pkg::mul_fx(z, z);
    a_next.xy  = bbvg_pkg::mul_fx(x, y);
    a_next.l0t = bbvg_pkg::ONE - x - y;
    a_next.l0q = bbvg_pkg::ONE - x - y - z;
    a_next.s   = bbvg_pkg::ONE - z;
    a_next.n2x = -(x <<< 1);
    a_next.n2y = -(y <<< 1);
    a_next.n2z = -(z <<< 1);
    a_next.p2z = z <<< 1;
  end

  always_comb begin
    bbvg_pkg::val_t ss;
    ss          = bbvg_pkg::mul_fx(ra.s, ra.s);
    b_next.cls  = ra.cls;
    b_next.x    = ra.x;
    b_next.y    = ra.y;
    b_next.z    = ra.z;
    b_next.xy   = ra.xy;
    b_next.n2x  = ra.n2x;
    b_next.n2y  = ra.n2y;
    b_next.n2z  = ra.n2z;
    b_next.mx   = bbvg_pkg::ONE - ra.xx;
    b_next.my   = bbvg_pkg::ONE - ra.yy;
    b_next.mz   = bbvg_pkg::ONE - ra.zz;
    b_next.l0tx = bbvg_pkg::mul_fx(ra.l0t, ra.x);
    b_next.l0ty = bbvg_pkg::mul_fx(ra.l0t, ra.y);
    b_next.xyz  = bbvg_pkg::mul_fx(ra.xy, ra.z);
    b_next.l0q  = ra.l0q;
    b_next.l0qx = bbvg_pkg::mul_fx(ra.l0q, ra.x);
    b_next.l0qy = bbvg_pkg::mul_fx(ra.l0q, ra.y);
    b_next.zs2  = bbvg_pkg::mul_fx(ra.p2z, ra.s);
    b_next.zn2x = bbvg_pkg::mul_fx(ra.z, ra.n2x);
    b_next.ax   = ss - ra.xx;
    b_next.ay   = ss - ra.yy;
    b_next.asum = (ss - ra.xx) + (ss - ra.yy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) ra <= a_next;
    if (en_b) rb <= b_next;
  end

  assign out_valid = vb;
  assign out_data  = rb;

endmodule

`default_nettype wire

// ===== rtl/bbvg_mid.sv =====
// Stage C: third product level for every shape class, then selection of the
// operands for the last product level by class. Uses bbvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbvg_mid (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire bbvg_pkg::b_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bbvg_pkg::c_t      out_data
);

  logic vc;
  logic en_c;
  bbvg_pkg::c_t rc, c_next;

  assign en_c     = !vc || out_ready;
  assign in_ready = en_c;

  always_comb begin
    bbvg_pkg::val_t t27, dtx, dty;
    bbvg_pkg::val_t tv, tgx, tgy, tgz;
    bbvg_pkg::val_t mxmy, n2xmy, mxn2y;
    bbvg_pkg::val_t zax, zn2xay, gzpre;
    t27    = bbvg_pkg::mul_fx(in_data.l0tx, in_data.y) * 27;
    dtx    = (in_data.l0ty - in_data.xy) * 27;
    dty    = (in_data.l0tx - in_data.xy) * 27;
    tv     = bbvg_pkg::mul_fx(in_data.l0q, in_data.xyz) <<< 8;
    tgx    = (bbvg_pkg::mul_fx(in_data.l0qy, in_data.z) - in_data.xyz) <<< 8;
    tgy    = (bbvg_pkg::mul_fx(in_data.l0qx, in_data.z) - in_data.xyz) <<< 8;
    tgz    = (bbvg_pkg::mul_fx(in_data.l0qx, in_data.y) - in_data.xyz) <<< 8;
    mxmy   = bbvg_pkg::mul_fx(in_data.mx, in_data.my);
    n2xmy  = bbvg_pkg::mul_fx(in_data.n2x, in_data.my);
    mxn2y  = bbvg_pkg::mul_fx(in_data.mx, in_data.n2y);
    zax    = bbvg_pkg::mul_fx(in_data.z, in_data.ax);
    zn2xay = bbvg_pkg::mul_fx(in_data.zn2x, in_data.ay);
    gzpre  = bbvg_pkg::mul_fx(in_data.ax, in_data.ay)
           - bbvg_pkg::mul_fx(in_data.zs2, in_data.asum);

    c_next.cls = in_data.cls;
    c_next.opa = '0;
    c_next.opb = '0;
    c_next.en  = 4'b0000;
    case (in_data.cls)
      bbvg_pkg::CLS_LINE: begin
        c_next.opa[0] = in_data.mx;
        c_next.opa[1] = in_data.n2x;
      end
      bbvg_pkg::CLS_TRI: begin
        c_next.opa[0] = t27;
        c_next.opa[1] = dtx;
        c_next.opa[2] = dty;
      end
      bbvg_pkg::CLS_TET: begin
        c_next.opa[0] = tv;
        c_next.opa[1] = tgx;
        c_next.opa[2] = tgy;
        c_next.opa[3] = tgz;
      end
      bbvg_pkg::CLS_QUAD: begin
        c_next.opa[0] = mxmy;
        c_next.opa[1] = n2xmy;
        c_next.opa[2] = mxn2y;
      end
      bbvg_pkg::CLS_HEX: begin
        c_next.opa[0] = mxmy;
        c_next.opa[1] = n2xmy;
        c_next.opa[2] = mxn2y;
        c_next.opa[3] = mxmy;
        c_next.opb[0] = in_data.mz;
        c_next.opb[1] = in_data.mz;
        c_next.opb[2] = in_data.mz;
        c_next.opb[3] = in_data.n2z;
        c_next.en     = 4'b1111;
      end
      bbvg_pkg::CLS_WEDGE: begin
        c_next.opa[0] = t27;
        c_next.opa[1] = dtx;
        c_next.opa[2] = dty;
        c_next.opa[3] = t27;
        c_next.opb[0] = in_data.mz;
        c_next.opb[1] = in_data.mz;
        c_next.opb[2] = in_data.mz;
        c_next.opb[3] = in_data.n2z;
        c_next.en     = 4'b1111;
      end
      bbvg_pkg::CLS_PYR: begin
        c_next.opa[0] = zax;
        c_next.opa[1] = zn2xay;
        c_next.opa[2] = zax;
        c_next.opa[3] = gzpre;
        c_next.opb[0] = in_data.ay;
        c_next.opb[2] = in_data.n2y;
        c_next.en     = 4'b0101;
      end
      default: begin
        c_next.opa = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en_c) begin
      vc <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) rc <= c_next;
  end

  assign out_valid = vc;
  assign out_data  = rc;

endmodule

`default_nettype wire

// ===== rtl/bbvg_back.sv =====
// Back stages: last product level on four lanes (stage D), then pyramid
// scaling and saturation into the output register (stage E). Uses bbvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbvg_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire bbvg_pkg::c_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bbvg_pkg::out_t    out_data
);

  logic vd, ve;
  logic en_d, en_e;
  bbvg_pkg::d_t   rd, d_next;
  bbvg_pkg::out_t re, e_next;

  assign en_e     = !ve || out_ready;
  assign en_d     = !vd || en_e;
  assign in_ready = en_d;

  always_comb begin
    d_next.cls = in_data.cls;
    for (int i = 0; i < 4; i++) begin
      d_next.r[i] = in_data.en[i] ? bbvg_pkg::mul_fx(in_data.opa[i], in_data.opb[i])
                                  : in_data.opa[i];
    end
  end

  always_comb begin
    bbvg_pkg::val_t [3:0] f;
    for (int i = 0; i < 4; i++) begin
      f[i] = (rd.cls == bbvg_pkg::CLS_PYR) ? bbvg_pkg::pyr_scale(rd.r[i]) : rd.r[i];
    end
    e_next.v  = bbvg_pkg::sat_out(f[0]);
    e_next.gx = bbvg_pkg::sat_out(f[1]);
    e_next.gy = bbvg_pkg::sat_out(f[2]);
    e_next.gz = bbvg_pkg::sat_out(f[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (en_d) vd <= in_valid;
      if (en_e) ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) rd <= d_next;
    if (en_e) re <= e_next;
  end

  assign out_valid = ve;
  assign out_data  = re;

endmodule

`default_nettype wire
